>>> rtl/core/tgc_pkg.sv
// Shared types, register indexes, event codes and limits of the touch gesture classifier.
package tgc_pkg;

    localparam int SCREEN_COLS_DEF = 240;
    localparam int SCREEN_ROWS_DEF = 320;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY_MS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEAT   = 3'd7;

    localparam logic [2:0] EVT_NONE       = 3'd0;
    localparam logic [2:0] EVT_HOLD       = 3'd1;
    localparam logic [2:0] EVT_SWIPE_UP   = 3'd2;
    localparam logic [2:0] EVT_SWIPE_DOWN = 3'd3;
    localparam logic [2:0] EVT_TAP        = 3'd4;

    localparam int STILL_LIMIT = 15;
    localparam int SWIPE_LIMIT = 25;
    localparam int TAP_DIST_SQ = 1600;
    localparam int TAP_TIME_MS = 500;

    localparam int RAW_W  = 12;
    localparam int TIME_W = 32;

    typedef struct packed {
        logic signed [15:0] x_raw_min;
        logic signed [15:0] x_raw_max;
        logic signed [15:0] y_raw_min;
        logic signed [15:0] y_raw_max;
        logic               swap_axes;
        logic [15:0]        debounce_ms;
        logic [15:0]        hold_delay_ms;
        logic [15:0]        hold_period_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [7:0]         event_x;
        logic [8:0]         event_y;
        logic signed [15:0] swipe_dy;
    } t_evt;

endpackage

>>> rtl/core/tgc_map.sv
// Shared raw-to-pixel mapping unit: one multiply, then a restoring divider one bit per cycle.
module tgc_map #(
    parameter int QW = 9
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tgc_pkg::RAW_W-1:0]  i_raw,
    input  logic signed [15:0]         i_lo,
    input  logic signed [15:0]         i_hi,
    input  logic [QW-1:0]              i_last,
    output logic                       o_done,
    output logic [QW-1:0]              o_pix
);

    localparam int NW = 16 + QW;
    localparam int CW = $clog2(QW + 1);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_MUL  = 3'd1;
    localparam logic [2:0] M_PRE  = 3'd2;
    localparam logic [2:0] M_DIV  = 3'd3;
    localparam logic [2:0] M_FIN  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [15:0]   r_dmag, n_dmag;
    logic [15:0]   r_smag, n_smag;
    logic          r_skip, n_skip;
    logic [NW-1:0] r_num, n_num;
    logic [15:0]   r_rem, n_rem;
    logic [QW-1:0] r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [QW-1:0] r_res, n_res;

    logic signed [16:0] w_diff;
    logic signed [16:0] w_span;
    logic [16:0]        w_trial;
    logic               w_ge;
    logic [QW-1:0]      w_quo;

    assign w_diff  = $signed({5'd0, i_raw}) - 17'(i_lo);
    assign w_span  = 17'(i_hi) - 17'(i_lo);
    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_smag};
    assign w_quo   = {r_quo[QW-2:0], w_ge};

    assign o_done = (r_state == M_FIN);
    assign o_pix  = r_res;

    always_comb begin
        n_state = r_state;
        n_dmag  = r_dmag;
        n_smag  = r_smag;
        n_skip  = r_skip;
        n_num   = r_num;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_res   = r_res;
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_dmag  = w_diff[16] ? 16'(-w_diff) : w_diff[15:0];
                    n_smag  = w_span[16] ? 16'(-w_span) : w_span[15:0];
                    n_skip  = (w_span == '0) || (w_diff[16] != w_span[16]);
                    n_state = M_MUL;
                end
            end
            M_MUL: begin
                n_num = NW'(r_dmag) * NW'(i_last);
                if (r_skip) begin
                    n_res   = '0;
                    n_state = M_FIN;
                end else begin
                    n_state = M_PRE;
                end
            end
            M_PRE: begin
                if (r_num[NW-1:QW] >= r_smag) begin
                    n_res   = i_last;
                    n_state = M_FIN;
                end else begin
                    n_rem   = r_num[NW-1:QW];
                    n_quo   = r_num[QW-1:0];
                    n_cnt   = '0;
                    n_state = M_DIV;
                end
            end
            M_DIV: begin
                n_rem = w_ge ? 16'(w_trial - {1'b0, r_smag}) : w_trial[15:0];
                n_quo = w_quo;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    n_res   = (w_quo > i_last) ? i_last : w_quo;
                    n_state = M_FIN;
                end
            end
            M_FIN: begin
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_dmag <= n_dmag;
        r_smag <= n_smag;
        r_skip <= n_skip;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

endmodule

>>> rtl/core/tgc_gesture.sv
// Press tracking state and gesture classification for one mapped touch sample.
module tgc_gesture #(
    parameter int QW = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  tgc_pkg::t_cfg               i_cfg,
    input  logic                        i_pen,
    input  logic [tgc_pkg::TIME_W-1:0]  i_time,
    input  logic [QW-1:0]               i_col,
    input  logic [QW-1:0]               i_row,
    output tgc_pkg::t_evt               o_evt
);

    logic               r_touching, n_touching;
    logic [QW-1:0]      r_start_col, n_start_col;
    logic [QW-1:0]      r_start_row, n_start_row;
    logic [QW-1:0]      r_last_col, n_last_col;
    logic [QW-1:0]      r_last_row, n_last_row;
    logic [31:0]        r_press_time, n_press_time;
    logic signed [31:0] r_vsum, n_vsum;
    logic [31:0]        r_next_hold, n_next_hold;
    logic               r_hold_seen, n_hold_seen;

    logic [31:0]        w_elapsed;
    logic signed [QW:0] w_delta;
    logic signed [32:0] w_sum;
    logic signed [31:0] w_vsum_add;
    logic [QW-1:0]      w_adx;
    logic [QW-1:0]      w_ady;
    logic [2*QW:0]      w_dist;
    logic signed [15:0] w_dy_sat;

    assign w_elapsed  = i_time - r_press_time;
    assign w_delta    = $signed({1'b0, i_row}) - $signed({1'b0, r_last_row});
    assign w_sum      = 33'(r_vsum) + 33'(w_delta);
    assign w_vsum_add = (w_sum[32] != w_sum[31]) ?
                        (w_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_sum[31:0];
    assign w_adx      = (r_last_col >= r_start_col) ? (r_last_col - r_start_col)
                                                    : (r_start_col - r_last_col);
    assign w_ady      = (r_last_row >= r_start_row) ? (r_last_row - r_start_row)
                                                    : (r_start_row - r_last_row);
    assign w_dist     = (2*QW+1)'(w_adx * w_adx) + (2*QW+1)'(w_ady * w_ady);
    assign w_dy_sat   = (r_vsum > 32767) ? 16'sh7FFF :
                        (r_vsum < -32768) ? 16'sh8000 : r_vsum[15:0];

    always_comb begin
        n_touching   = r_touching;
        n_start_col  = r_start_col;
        n_start_row  = r_start_row;
        n_last_col   = r_last_col;
        n_last_row   = r_last_row;
        n_press_time = r_press_time;
        n_vsum       = r_vsum;
        n_next_hold  = r_next_hold;
        n_hold_seen  = r_hold_seen;
        o_evt        = '0;
        o_evt.event_kind = tgc_pkg::EVT_NONE;
        if (i_pen && !r_touching) begin
            if (!(r_press_time != '0 && w_elapsed < 32'(i_cfg.debounce_ms))) begin
                n_start_col  = i_col;
                n_last_col   = i_col;
                n_start_row  = i_row;
                n_last_row   = i_row;
                n_press_time = i_time;
                n_next_hold  = '0;
                n_hold_seen  = 1'b0;
                n_vsum       = '0;
                n_touching   = 1'b1;
            end
        end else if (i_pen && r_touching) begin
            n_vsum     = w_vsum_add;
            n_last_col = i_col;
            n_last_row = i_row;
            if (w_vsum_add < tgc_pkg::STILL_LIMIT && w_vsum_add > -tgc_pkg::STILL_LIMIT) begin
                if (r_next_hold == '0 && w_elapsed >= 32'(i_cfg.hold_delay_ms)) begin
                    n_next_hold      = i_time + 32'(i_cfg.hold_period_ms);
                    n_hold_seen      = 1'b1;
                    o_evt.event_kind = tgc_pkg::EVT_HOLD;
                    o_evt.event_x    = 8'(r_start_col);
                    o_evt.event_y    = 9'(r_start_row);
                end else if (r_next_hold != '0 && i_time >= r_next_hold) begin
                    n_next_hold      = i_time + 32'(i_cfg.hold_period_ms);
                    o_evt.event_kind = tgc_pkg::EVT_HOLD;
                    o_evt.event_x    = 8'(r_start_col);
                    o_evt.event_y    = 9'(r_start_row);
                end
            end
        end else if (!i_pen && r_touching) begin
            n_touching = 1'b0;
            if (r_hold_seen) begin
                o_evt.event_kind = tgc_pkg::EVT_NONE;
            end else if (r_vsum >= tgc_pkg::SWIPE_LIMIT || r_vsum <= -tgc_pkg::SWIPE_LIMIT) begin
                o_evt.event_kind = r_vsum[31] ? tgc_pkg::EVT_SWIPE_UP : tgc_pkg::EVT_SWIPE_DOWN;
                o_evt.swipe_dy   = w_dy_sat;
            end else if (32'(w_dist) < 32'(tgc_pkg::TAP_DIST_SQ) &&
                         w_elapsed < 32'(tgc_pkg::TAP_TIME_MS)) begin
                o_evt.event_kind = tgc_pkg::EVT_TAP;
                o_evt.event_x    = 8'(r_start_col);
                o_evt.event_y    = 9'(r_start_row);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touching   <= 1'b0;
            r_start_col  <= '0;
            r_start_row  <= '0;
            r_last_col   <= '0;
            r_last_row   <= '0;
            r_press_time <= '0;
            r_vsum       <= '0;
            r_next_hold  <= '0;
            r_hold_seen  <= 1'b0;
        end else if (i_step) begin
            r_touching   <= n_touching;
            r_start_col  <= n_start_col;
            r_start_row  <= n_start_row;
            r_last_col   <= n_last_col;
            r_last_row   <= n_last_row;
            r_press_time <= n_press_time;
            r_vsum       <= n_vsum;
            r_next_hold  <= n_next_hold;
            r_hold_seen  <= n_hold_seen;
        end
    end

endmodule

>>> rtl/core/touch_gesture_classifier.sv
// Top level of the touch gesture classifier: channels, config registers, axis sequencer.
//
//  channel   direction  handshake                      payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready tuser pen_down, tdata raw_x,raw_y,time_ms
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready tuser event_kind, tdata x,y,dy
//  cfg       in         i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
//  QW = clog2(max(SCREEN_COLS, SCREEN_ROWS)). A sample is mapped by the bit-serial divider,
//  run once for the column and once for the row; an axis with zero span or a reading on the
//  other side of the low bound from the high bound skips the divide.
//  Reset loads the calibration defaults and clears all press tracking state.
//  A result waiting in the output register does not block the next sample from mapping;
//  only the final commit waits for the output register to free up.
module touch_gesture_classifier #(
    parameter int SCREEN_COLS = tgc_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = tgc_pkg::SCREEN_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [11:0] raw_x, [23:12] raw_y, [55:24] time_ms
    input  logic [55:0]                     i_s_axis_tdata,
    // [0] pen_down
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] event_x, [16:8] event_y, [32:17] swipe_dy, [39:33] zero
    output logic [39:0]                     o_m_axis_tdata,
    // [2:0] event_kind
    output logic [2:0]                      o_m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SCREEN_MAX = (SCREEN_COLS > SCREEN_ROWS) ? SCREEN_COLS : SCREEN_ROWS;
    localparam int QW         = $clog2(SCREEN_MAX);
    localparam logic [QW-1:0] COL_LAST = QW'(SCREEN_COLS - 1);
    localparam logic [QW-1:0] ROW_LAST = QW'(SCREEN_ROWS - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_COL_GO   = 3'd1;
    localparam logic [2:0] S_COL_WAIT = 3'd2;
    localparam logic [2:0] S_ROW_GO   = 3'd3;
    localparam logic [2:0] S_ROW_WAIT = 3'd4;
    localparam logic [2:0] S_UPD      = 3'd5;

    logic [2:0]                      r_state, n_state;
    logic                            r_pen;
    logic [tgc_pkg::RAW_W-1:0]       r_raw_x;
    logic [tgc_pkg::RAW_W-1:0]       r_raw_y;
    logic [tgc_pkg::TIME_W-1:0]      r_time;
    logic [QW-1:0]                   r_col;
    logic [QW-1:0]                   r_row;
    tgc_pkg::t_cfg                   r_cfg;
    logic                            r_out_valid;
    tgc_pkg::t_evt                   r_out;

    logic                            w_in_acc;
    logic                            w_row_axis;
    logic                            w_map_start;
    logic [tgc_pkg::RAW_W-1:0]       w_map_raw;
    logic signed [15:0]              w_map_lo;
    logic signed [15:0]              w_map_hi;
    logic [QW-1:0]                   w_map_last;
    logic                            w_map_done;
    logic [QW-1:0]                   w_map_pix;
    logic                            w_commit;
    tgc_pkg::t_evt                   w_evt;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_row_axis  = (r_state == S_ROW_GO) || (r_state == S_ROW_WAIT);
    assign w_map_start = (r_state == S_COL_GO) || (r_state == S_ROW_GO);
    assign w_map_raw   = (r_cfg.swap_axes ^ w_row_axis) ? r_raw_y : r_raw_x;
    assign w_map_lo    = w_row_axis ? r_cfg.y_raw_min : r_cfg.x_raw_min;
    assign w_map_hi    = w_row_axis ? r_cfg.y_raw_max : r_cfg.x_raw_max;
    assign w_map_last  = w_row_axis ? ROW_LAST : COL_LAST;

    assign w_commit = (r_state == S_UPD) && (!r_out_valid || i_m_axis_tready);

    tgc_map #(
        .QW(QW)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_map_start),
        .i_raw   (w_map_raw),
        .i_lo    (w_map_lo),
        .i_hi    (w_map_hi),
        .i_last  (w_map_last),
        .o_done  (w_map_done),
        .o_pix   (w_map_pix)
    );

    tgc_gesture #(
        .QW(QW)
    ) u_gesture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_commit),
        .i_cfg   (r_cfg),
        .i_pen   (r_pen),
        .i_time  (r_time),
        .i_col   (r_col),
        .i_row   (r_row),
        .o_evt   (w_evt)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_COL_GO;
                end
            end
            S_COL_GO: begin
                n_state = S_COL_WAIT;
            end
            S_COL_WAIT: begin
                if (w_map_done) begin
                    n_state = S_ROW_GO;
                end
            end
            S_ROW_GO: begin
                n_state = S_ROW_WAIT;
            end
            S_ROW_WAIT: begin
                if (w_map_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_in_acc) begin
            r_pen   <= i_s_axis_tuser;
            r_raw_x <= i_s_axis_tdata[11:0];
            r_raw_y <= i_s_axis_tdata[23:12];
            r_time  <= i_s_axis_tdata[55:24];
        end
        if (w_map_done && !w_row_axis) begin
            r_col <= w_map_pix;
        end
        if (w_map_done && w_row_axis) begin
            r_row <= w_map_pix;
        end
        if (w_commit) begin
            r_out <= w_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_raw_min      <= 16'sd200;
            r_cfg.x_raw_max      <= 16'sd3900;
            r_cfg.y_raw_min      <= 16'sd200;
            r_cfg.y_raw_max      <= 16'sd3900;
            r_cfg.swap_axes      <= 1'b1;
            r_cfg.debounce_ms    <= 16'd60;
            r_cfg.hold_delay_ms  <= 16'd500;
            r_cfg.hold_period_ms <= 16'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tgc_pkg::REG_X_RAW_MIN:     r_cfg.x_raw_min      <= $signed(i_cfg_data);
                tgc_pkg::REG_X_RAW_MAX:     r_cfg.x_raw_max      <= $signed(i_cfg_data);
                tgc_pkg::REG_Y_RAW_MIN:     r_cfg.y_raw_min      <= $signed(i_cfg_data);
                tgc_pkg::REG_Y_RAW_MAX:     r_cfg.y_raw_max      <= $signed(i_cfg_data);
                tgc_pkg::REG_SWAP_AXES:     r_cfg.swap_axes      <= i_cfg_data[0];
                tgc_pkg::REG_DEBOUNCE_MS:   r_cfg.debounce_ms    <= i_cfg_data;
                tgc_pkg::REG_HOLD_DELAY_MS: r_cfg.hold_delay_ms  <= i_cfg_data;
                tgc_pkg::REG_HOLD_REPEAT:   r_cfg.hold_period_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.event_kind;
    assign o_m_axis_tdata  = {7'd0, r_out.swipe_dy, r_out.event_y, r_out.event_x};

endmodule
